@@ src/hafl_pkg.sv @@
// shared constants and types of the hex ascii frame link
package hafl_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int POS_W        = 7;
    localparam int TIMER_W      = 16;
    localparam int IN_DATA_W    = 24;
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 32;

    typedef struct packed {
        logic [7:0]         start_char;
        logic [7:0]         end_char;
        logic [TIMER_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic emit_adv;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_run;
        logic emit_last;
    } status_t;

endpackage

@@ src/hafl_ram.sv @@
// generic single-port-write ram with registered read
module hafl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/hafl_regs.sv @@
// configuration registers behind the apb port
module hafl_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hafl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hafl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hafl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output hafl_pkg::cfg_t                  cfg
);
    import hafl_pkg::*;

    localparam logic [1:0] REG_START   = 2'd0;
    localparam logic [1:0] REG_END     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    logic [7:0]         start_reg;
    logic [7:0]         end_reg;
    logic [TIMER_W-1:0] timeout_reg;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= 8'd58;
            end_reg     <= 8'd10;
            timeout_reg <= 16'd1000;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_START:   start_reg   <= pwdata[7:0];
                REG_END:     end_reg     <= pwdata[7:0];
                REG_TIMEOUT: timeout_reg <= pwdata[TIMER_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_START:   prdata = {24'd0, start_reg};
            REG_END:     prdata = {24'd0, end_reg};
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.start_char    = start_reg;
    assign cfg.end_char      = end_reg;
    assign cfg.timeout_ticks = timeout_reg;

endmodule

@@ src/hafl_datapath.sv @@
// link state, frame stores, step logic and output register
module hafl_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hafl_pkg::cfg_t                 cfg,
    input  hafl_pkg::cmd_t                 cmd,
    output hafl_pkg::status_t              status,
    input  logic [hafl_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import hafl_pkg::*;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RX_START = 3'd1;
    localparam logic [2:0] PH_RX_HB    = 3'd2;
    localparam logic [2:0] PH_RX_DATA  = 3'd3;
    localparam logic [2:0] PH_TX_HB    = 3'd4;
    localparam logic [2:0] PH_TX_DATA  = 3'd5;
    localparam logic [2:0] PH_TX_END   = 3'd6;

    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(BUFFER_DEPTH);
    localparam logic [POS_W-1:0] PEND_MAX  = '1;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= "0" && c <= "9")
        begin
            v = c - 8'h30;
        end
        else if (c >= "a" && c <= "f")
        begin
            v = c - 8'h57;
        end
        else if (c >= "A" && c <= "F")
        begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] nib_char(input logic [3:0] n);
        return (n < 4'hA) ? 8'h30 + {4'd0, n} : 8'h37 + {4'd0, n};
    endfunction

    // latched input item
    logic               in_op_reg;
    logic               in_rxv_reg;
    logic [7:0]         in_rxc_reg;
    logic               in_ready_reg;
    logic               in_tick_reg;
    logic [7:0]         in_lb_reg;

    logic [2:0]         phase_reg, phase_next;
    logic [7:0]         hn_reg, hn_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   pend_reg, pend_next;
    logic [POS_W-1:0]   wptr_reg, wptr_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [POS_W-1:0]   emit_cnt_reg, emit_cnt_next;

    logic               out_valid_reg;
    logic [7:0]         out_value_reg;
    logic               out_kind_reg;
    logic               out_last_reg;

    logic [TIMER_W-1:0] t_dec;
    logic               res_valid;
    logic [7:0]         res_value;
    logic               rx_we;
    logic [7:0]         rx_wdata;
    logic               tx_we;
    logic               emit_run;
    logic [7:0]         rx_rdata;
    logic [7:0]         tx_rdata;
    logic [7:0]         tx_byte;
    logic [POS_W-1:0]   pend_dec;
    logic [POS_W-1:0]   emit_cnt_inc;
    logic               out_free;
    logic               out_load;
    logic               emit_last;

    assign out_free     = !out_valid_reg || m_tready;
    assign emit_cnt_inc = emit_cnt_reg + 1'b1;
    assign emit_last    = (emit_cnt_inc == pos_reg);
    assign tx_byte      = (pos_reg < DEPTH_POS) ? tx_rdata : 8'd0;
    assign t_dec        = (in_tick_reg && timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign pend_dec     = (pend_reg != '0) ? pend_reg - 1'b1 : pend_reg;
    assign rx_wdata     = {hex_val(hn_reg), hex_val(in_rxc_reg)};

    always_comb
    begin
        phase_next = phase_reg;
        hn_next    = hn_reg;
        pos_next   = pos_reg;
        pend_next  = pend_reg;
        wptr_next  = wptr_reg;
        timer_next = timer_reg;
        res_valid  = 1'b0;
        res_value  = 8'd0;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        emit_run   = 1'b0;
        if (in_op_reg)
        begin
            if (wptr_reg < DEPTH_POS && pend_reg != PEND_MAX)
            begin
                tx_we     = 1'b1;
                wptr_next = wptr_reg + 1'b1;
                pend_next = pend_reg + 1'b1;
            end
        end
        else
        begin
            timer_next = t_dec;
            unique case (phase_reg)
                PH_RX_START:
                begin
                    if (in_rxv_reg)
                    begin
                        if (hex_ok(in_rxc_reg))
                        begin
                            hn_next    = in_rxc_reg;
                            timer_next = cfg.timeout_ticks;
                            phase_next = PH_RX_HB;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    if (timer_next == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_RX_HB:
                begin
                    if (in_rxv_reg)
                    begin
                        if (hex_ok(in_rxc_reg))
                        begin
                            rx_we      = (pos_reg < DEPTH_POS);
                            pos_next   = pos_reg + 1'b1;
                            timer_next = cfg.timeout_ticks;
                            phase_next = PH_RX_DATA;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    if (timer_next == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_RX_DATA:
                begin
                    if (in_rxv_reg)
                    begin
                        if (hex_ok(in_rxc_reg))
                        begin
                            if (pos_reg < DEPTH_POS)
                            begin
                                hn_next    = in_rxc_reg;
                                timer_next = cfg.timeout_ticks;
                                phase_next = PH_RX_HB;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        else if (in_rxc_reg == cfg.end_char)
                        begin
                            emit_run   = (pos_reg != '0);
                            wptr_next  = '0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    if (timer_next == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_TX_HB, PH_TX_DATA, PH_TX_END:
                begin
                    if (in_ready_reg)
                    begin
                        res_valid = 1'b1;
                        if (phase_reg == PH_TX_HB)
                        begin
                            res_value  = nib_char(tx_byte[7:4]);
                            timer_next = cfg.timeout_ticks;
                            phase_next = PH_TX_DATA;
                        end
                        else if (phase_reg == PH_TX_DATA)
                        begin
                            res_value  = nib_char(tx_byte[3:0]);
                            pos_next   = pos_reg + 1'b1;
                            pend_next  = pend_dec;
                            timer_next = cfg.timeout_ticks;
                            phase_next = (pend_dec != '0) ? PH_TX_HB : PH_TX_END;
                        end
                        else
                        begin
                            res_value  = cfg.end_char;
                            wptr_next  = '0;
                            phase_next = PH_IDLE;
                        end
                    end
                    if (timer_next == '0 && phase_next != PH_IDLE)
                    begin
                        pend_next  = '0;
                        wptr_next  = '0;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (in_rxv_reg)
                    begin
                        if (in_rxc_reg == cfg.start_char)
                        begin
                            pos_next   = '0;
                            timer_next = cfg.timeout_ticks;
                            phase_next = PH_RX_START;
                        end
                    end
                    else if (pend_reg != '0 && in_ready_reg)
                    begin
                        pos_next   = '0;
                        res_valid  = 1'b1;
                        res_value  = cfg.start_char;
                        timer_next = cfg.timeout_ticks;
                        phase_next = PH_TX_HB;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        emit_cnt_next = emit_cnt_reg;
        if (cmd.exec && emit_run)
        begin
            emit_cnt_next = '0;
        end
        else if (cmd.emit_adv)
        begin
            emit_cnt_next = emit_cnt_inc;
        end
    end

    assign out_load = (cmd.exec && res_valid) || cmd.emit_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hn_reg        <= '0;
            pos_reg       <= '0;
            pend_reg      <= '0;
            wptr_reg      <= '0;
            timer_reg     <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                phase_reg <= phase_next;
                hn_reg    <= hn_next;
                pos_reg   <= pos_next;
                pend_reg  <= pend_next;
                wptr_reg  <= wptr_next;
                timer_reg <= timer_next;
            end
            emit_cnt_reg <= emit_cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            in_op_reg    <= s_tuser;
            in_rxv_reg   <= s_tdata[0];
            in_rxc_reg   <= s_tdata[8:1];
            in_ready_reg <= s_tdata[9];
            in_tick_reg  <= s_tdata[10];
            in_lb_reg    <= s_tdata[18:11];
        end
        if (out_load)
        begin
            out_value_reg <= cmd.emit_adv ? rx_rdata : res_value;
            out_kind_reg  <= cmd.emit_adv;
            out_last_reg  <= cmd.emit_adv && emit_last;
        end
    end

    hafl_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (cmd.exec && rx_we),
        .waddr (pos_reg[ADDR_W-1:0]),
        .wdata (rx_wdata),
        .raddr (emit_cnt_next[ADDR_W-1:0]),
        .rdata (rx_rdata)
    );

    hafl_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (cmd.exec && tx_we),
        .waddr (wptr_reg[ADDR_W-1:0]),
        .wdata (in_lb_reg),
        .raddr (pos_reg[ADDR_W-1:0]),
        .rdata (tx_rdata)
    );

    assign status.out_free  = out_free;
    assign status.emit_run  = emit_run;
    assign status.emit_last = emit_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ src/hafl_ctrl.sv @@
// item sequencer: accept, execute one link step, stream a received frame
module hafl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  hafl_pkg::status_t   status,
    output hafl_pkg::cmd_t      cmd
);
    import hafl_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_EXEC = 2'd1;
    localparam logic [1:0] C_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.emit_adv  = 1'b0;
        s_tready      = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = C_EXEC;
                end
            end
            C_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = status.emit_run ? C_EMIT : C_IDLE;
                end
            end
            C_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_adv = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = C_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/hex_ascii_frame_link.sv @@
// top level of the hex ascii frame link
// usage:
// - slave stream s_*: one item per link step or byte load; s_tuser is the operation
//   (1 appends load_byte to the transmit store), s_tdata carries the step inputs
// - master stream m_*: m_tdata is the character to send or a received byte,
//   m_tuser tells which (1 = received byte), m_tlast marks the final byte of a frame
// - apb port holds start_char (0x0), end_char (0x4) and timeout_ticks (0x8)
// timing:
// - an accepted item is latched in the input registers and executed once the output
//   register is free; a transmit character is then registered and driven on m_tdata
// - a frame end streams the stored bytes at one per cycle from the rx store while
//   the output register is free
// - s_tready is high only while no item is in work; the tx store is read ahead of
//   execution through its registered port
// reset: all link state clears, phase goes idle, registers take their defaults;
//   the byte stores hold no defined contents until written
// stall: the output register holds its item while m_tready is low and the
//   sequencer waits before executing or emitting the next result
module hex_ascii_frame_link (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] rx_valid, [8:1] rx_char, [9] link_ready, [10] tick, [18:11] load_byte
    input  logic [hafl_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] value
    output logic [7:0]                      m_tdata,
    // [0] kind
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hafl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hafl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hafl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import hafl_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    hafl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hafl_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    hafl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

endmodule
